FILE: src/text_console_cursor_engine_assert.svh
// ----------------------------------------------------------------------------
// text console cursor engine assertion macros
// concurrent check macros shared by the engine's modules; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

`ifndef SYNTH

// plain property check, off during reset
`define TCCE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tcce check failed");

// same-cycle implication check, off during reset
`define TCCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcce implication check failed");

`else

`define TCCE_ASSERT(label, clk, rst, prop)

`define TCCE_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// screen geometry, field widths, character codes and shared types
// ----------------------------------------------------------------------------
package tcce_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;

   // field widths
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int ADDR_W  = 11;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int DATA_W  = 12;

   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

   // character codes
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

   // tab expands into this many blank cells
   localparam int TAB_WIDTH = 3;
   localparam int TAB_W     = $clog2(TAB_WIDTH);
   localparam logic [TAB_W-1:0] TAB_LAST = TAB_W'(TAB_WIDTH - 1);

   localparam logic [COLOR_W-1:0] COLOR_RESET = 4'hF;

   // result kinds
   localparam logic KIND_CELL   = 1'b0;
   localparam logic KIND_CURSOR = 1'b1;

   // command queue, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_TAB,
      OP_MARK
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CHAR_W-1:0]     char_code;
      logic                  show_cursor;
   } cmd_type;

   typedef enum logic {
      BK_CELLS,
      BK_CURSOR
   } back_state_type;

endpackage

FILE: src/tcce_if.sv
// ----------------------------------------------------------------------------
// tcce channel interfaces
// valid/ready channels for command items, result items and the color register
// ----------------------------------------------------------------------------
interface tcce_req_if import tcce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [CHAR_W-1:0] char_code;
   logic              show_cursor;

   modport source (output valid, output func, output char_code, output show_cursor,
                   input ready);
   modport sink   (input valid, input func, input char_code, input show_cursor,
                   output ready);
endinterface

interface tcce_rsp_if import tcce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] cell_address;
   logic [DATA_W-1:0] cell_data;
   logic              last;

   modport source (output valid, output kind, output cell_address, output cell_data,
                   output last, input ready);
   modport sink   (input valid, input kind, input cell_address, input cell_data,
                   input last, output ready);
endinterface

interface tcce_csr_if import tcce_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] text_color;

   modport source (output valid, output text_color, input ready);
   modport sink   (input valid, input text_color, output ready);
endinterface

FILE: src/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// accepts command items and classifies them into engine operations
// ----------------------------------------------------------------------------
module tcce_front import tcce_pkg::*; (
   tcce_req_if.sink req,
   output logic     push_valid,
   input  logic     push_ready,
   output cmd_type  push_item
);

   op_type op;

   always_comb begin
      if (req.func) begin
         op = OP_MARK;
      end else begin
         unique case (req.char_code)
            CODE_NEWLINE:   op = OP_NEWLINE;
            CODE_BACKSPACE: op = OP_BACKSPACE;
            CODE_TAB:       op = OP_TAB;
            default:        op = OP_PUT;
         endcase
      end
   end

   assign push_valid            = req.valid;
   assign req.ready             = push_ready;
   assign push_item.op          = op;
   assign push_item.char_code   = req.char_code;
   assign push_item.show_cursor = req.show_cursor;

endmodule

FILE: src/tcce_queue.sv
// ----------------------------------------------------------------------------
// tcce_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_assert.svh"

module tcce_queue import tcce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_item,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_item
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   // pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `TCCE_ASSERT(a_count_tracks, clock, reset, 1'b1 |=> count_ff == $past(count_in))
   `TCCE_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `TCCE_ASSERT_IMPL(a_pop_has_item, clock, reset, pop_ready, pop_valid)

endmodule

FILE: src/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// cursor state, edit boundary, result generation; one per cycle unless stalled
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_assert.svh"

module tcce_back import tcce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [COLOR_W-1:0] text_color,
   input  logic               q_valid,
   output logic               q_pop,
   input  cmd_type            q_item,
   tcce_rsp_if.source         rsp
);

   back_state_type    state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] boundary_ff, boundary_in;
   logic              bvalid_ff, bvalid_in;
   logic [TAB_W-1:0]  tab_step_ff, tab_step_in;

   logic              rsp_valid_ff;
   logic              rsp_kind_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic              can_emit;
   logic              emit;
   logic              e_kind;
   logic [ADDR_W-1:0] e_addr;
   logic [CHAR_W-1:0] e_char;
   logic              e_last;

   logic              col_wrap, row_wrap;
   logic [COL_W-1:0]  adv_col;
   logic [ROW_W-1:0]  adv_row, nl_row;
   logic [ADDR_W-1:0] adv_addr, nl_addr, prev_addr;
   logic              bs_block;

   assign can_emit = !rsp_valid_ff || rsp.ready;

   // cursor moves, address kept alongside row and column
   always_comb begin
      col_wrap  = (col_ff == COL_LAST);
      row_wrap  = (row_ff == ROW_LAST);
      nl_row    = row_wrap ? '0 : row_ff + 1'b1;
      adv_col   = col_wrap ? '0 : col_ff + 1'b1;
      adv_row   = col_wrap ? nl_row : row_ff;
      adv_addr  = (col_wrap && row_wrap) ? '0 : addr_ff + 1'b1;
      nl_addr   = row_wrap ? '0 : addr_ff - ADDR_W'(col_ff) + ROW_STRIDE;
      prev_addr = addr_ff - 1'b1;
      bs_block  = (col_ff == '0) || (bvalid_ff && (prev_addr < boundary_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CELLS: begin
            if (q_valid && can_emit && q_item.show_cursor &&
                ((q_item.op == OP_PUT) ||
                 ((q_item.op == OP_BACKSPACE) && !bs_block) ||
                 ((q_item.op == OP_TAB) && (tab_step_ff == TAB_LAST)))) begin
               state_in = BK_CURSOR;
            end
         end
         BK_CURSOR: begin
            if (can_emit) begin
               state_in = BK_CELLS;
            end
         end
         default: state_in = BK_CELLS;
      endcase
   end

   // datapath and result selection
   always_comb begin
      q_pop       = 1'b0;
      emit        = 1'b0;
      e_kind      = KIND_CELL;
      e_addr      = addr_ff;
      e_char      = CODE_SPACE;
      e_last      = 1'b0;
      col_in      = col_ff;
      row_in      = row_ff;
      addr_in     = addr_ff;
      boundary_in = boundary_ff;
      bvalid_in   = bvalid_ff;
      tab_step_in = tab_step_ff;
      unique case (state_ff)
         BK_CELLS: begin
            if (q_valid) begin
               unique case (q_item.op)
                  OP_MARK: begin
                     boundary_in = addr_ff;
                     bvalid_in   = 1'b1;
                     q_pop       = 1'b1;
                  end
                  OP_NEWLINE: begin
                     if (!q_item.show_cursor || can_emit) begin
                        col_in  = '0;
                        row_in  = nl_row;
                        addr_in = nl_addr;
                        q_pop   = 1'b1;
                        emit    = q_item.show_cursor;
                        e_kind  = KIND_CURSOR;
                        e_addr  = nl_addr;
                        e_last  = 1'b1;
                     end
                  end
                  OP_BACKSPACE: begin
                     if (bs_block) begin
                        q_pop = 1'b1;
                     end else if (can_emit) begin
                        emit    = 1'b1;
                        e_addr  = prev_addr;
                        e_last  = !q_item.show_cursor;
                        col_in  = col_ff - 1'b1;
                        addr_in = prev_addr;
                        q_pop   = !q_item.show_cursor;
                     end
                  end
                  OP_TAB: begin
                     if (can_emit) begin
                        emit    = 1'b1;
                        col_in  = adv_col;
                        row_in  = adv_row;
                        addr_in = adv_addr;
                        if (tab_step_ff == TAB_LAST) begin
                           tab_step_in = '0;
                           e_last      = !q_item.show_cursor;
                           q_pop       = !q_item.show_cursor;
                        end else begin
                           tab_step_in = tab_step_ff + 1'b1;
                        end
                     end
                  end
                  OP_PUT: begin
                     if (can_emit) begin
                        emit    = 1'b1;
                        e_char  = q_item.char_code;
                        e_last  = !q_item.show_cursor;
                        col_in  = adv_col;
                        row_in  = adv_row;
                        addr_in = adv_addr;
                        q_pop   = !q_item.show_cursor;
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         BK_CURSOR: begin
            if (can_emit) begin
               emit   = 1'b1;
               e_kind = KIND_CURSOR;
               e_last = 1'b1;
               q_pop  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CELLS;
         col_ff       <= '0;
         row_ff       <= '0;
         addr_ff      <= '0;
         boundary_ff  <= '0;
         bvalid_ff    <= 1'b0;
         tab_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         addr_ff      <= addr_in;
         boundary_ff  <= boundary_in;
         bvalid_ff    <= bvalid_in;
         tab_step_ff  <= tab_step_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= e_kind;
         rsp_addr_ff <= e_addr;
         rsp_data_ff <= (e_kind == KIND_CURSOR) ? '0 : {text_color, e_char};
         rsp_last_ff <= e_last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_kind_ff;
   assign rsp.cell_address = rsp_addr_ff;
   assign rsp.cell_data    = rsp_data_ff;
   assign rsp.last         = rsp_last_ff;

   `TCCE_ASSERT(a_cursor_in_range, clock, reset, (col_ff <= COL_LAST) && (row_ff <= ROW_LAST))
   `TCCE_ASSERT_IMPL(a_cursor_has_item, clock, reset, state_ff == BK_CURSOR, q_valid)
   `TCCE_ASSERT_IMPL(a_tab_step_owner, clock, reset, tab_step_ff != '0, q_item.op == OP_TAB)

endmodule

FILE: src/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// text-mode console cursor engine: characters in, cell writes and cursor moves out
// ----------------------------------------------------------------------------
// Each command item either puts a character at the cursor or marks the cursor
// as the protected-edit boundary. A put of a printable code gives one cell
// write, a tab three blank cell writes, a backspace one blank cell write (or
// nothing at column 0 or before the boundary), a newline no cell write. With
// show_cursor set, a cursor position result follows, flagged last, except
// for a mark or an ignored backspace. The back part produces one result
// per clock while rsp_bus takes them, through a single output register, so
// an item holds the back part until its last result is registered.
// A two-entry command queue sits between the command port and the back part,
// so new items keep being taken while results wait on rsp_bus. The color
// register resets to 15 and should only be written while the engine is idle.
// ----------------------------------------------------------------------------
module text_console_cursor_engine import tcce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tcce_req_if.sink   req_bus,
   tcce_rsp_if.source rsp_bus,
   tcce_csr_if.sink   csr_bus
);

   // foreground color register
   logic [COLOR_W-1:0] color_ff, color_in;

   // front to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_item;

   // queue to back
   logic    q_valid;
   logic    q_pop;
   cmd_type q_item;

   // register writes always taken
   assign csr_bus.ready = 1'b1;
   assign color_in      = csr_bus.valid ? csr_bus.text_color : color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else begin
         color_ff <= color_in;
      end
   end

   // decode incoming items into operations
   tcce_front u_front (
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouples item intake from result generation
   tcce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_item   (q_item)
   );

   // cursor tracking and result sequencing
   tcce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .text_color (color_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp        (rsp_bus)
   );

endmodule

FILE: tb/sv/tcce_screen_check.sv
// ----------------------------------------------------------------------------
// tcce_screen_check
// watches the command, result and color channels of the cursor engine, keeps
// its own cursor, boundary and color, and compares every result item in order
// ----------------------------------------------------------------------------
module tcce_screen_check import tcce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tcce_req_if        req_mon,
   tcce_rsp_if        rsp_mon,
   tcce_csr_if        csr_mon,
   output int         fail_count,
   output int         results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] cell_address;
      logic [DATA_W-1:0] cell_data;
      logic              last;
   } screen_result_type;

   screen_result_type screen_writes_q[$];

   logic [ROW_W-1:0]   cur_row;
   logic [COL_W-1:0]   cur_col;
   logic [ADDR_W-1:0]  guard_addr;
   logic               guard_set;
   logic [COLOR_W-1:0] fg_color;
   int                 mismatches = 0;
   int                 queued = 0;

   assign fail_count  = mismatches;
   assign results_due = queued;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
   endtask

   // address wraps at 11 bits like the hardware
   function automatic logic [ADDR_W-1:0] screen_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
      return ADDR_W'(int'(r) * COLUMNS + int'(c));
   endfunction

   function automatic void next_row();
      cur_row = (int'(cur_row) + 1 >= ROWS) ? '0 : cur_row + 1'b1;
   endfunction

   function automatic void step_cursor();
      if (int'(cur_col) + 1 >= COLUMNS) begin
         cur_col = '0;
         next_row();
      end else begin
         cur_col = cur_col + 1'b1;
      end
   endfunction

   function automatic void add_result(input logic kind, input logic [DATA_W-1:0] data);
      screen_writes_q.push_back('{kind, screen_addr(cur_row, cur_col), data, 1'b0});
   endfunction

   function automatic void predict_screen(input logic func, input logic [CHAR_W-1:0] ch,
                                          input logic upd);
      op_type op;
      int     prior_count;
      prior_count = screen_writes_q.size();
      if (func)
         op = OP_MARK;
      else if (ch == CODE_NEWLINE)
         op = OP_NEWLINE;
      else if (ch == CODE_BACKSPACE)
         op = OP_BACKSPACE;
      else if (ch == CODE_TAB)
         op = OP_TAB;
      else
         op = OP_PUT;

      case (op)
         OP_MARK: begin
            guard_addr = screen_addr(cur_row, cur_col);
            guard_set  = 1'b1;
            return;
         end
         OP_NEWLINE: begin
            cur_col = '0;
            next_row();
         end
         OP_BACKSPACE: begin
            // column zero or a protected cell: nothing at all
            if (cur_col == '0)
               return;
            if (guard_set && screen_addr(cur_row, cur_col - 1'b1) < guard_addr)
               return;
            cur_col = cur_col - 1'b1;
            add_result(KIND_CELL, {fg_color, CODE_SPACE});
         end
         OP_TAB: begin
            repeat (TAB_WIDTH) begin
               add_result(KIND_CELL, {fg_color, CODE_SPACE});
               step_cursor();
            end
         end
         default: begin
            add_result(KIND_CELL, {fg_color, ch});
            step_cursor();
         end
      endcase

      if (upd)
         add_result(KIND_CURSOR, '0);
      if (screen_writes_q.size() > prior_count)
         screen_writes_q[screen_writes_q.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      screen_result_type want;
      if (reset) begin
         cur_row    = '0;
         cur_col    = '0;
         guard_addr = '0;
         guard_set  = 1'b0;
         fg_color   = COLOR_RESET;
         screen_writes_q.delete();
      end else begin
         // results first: an item accepted on this edge cannot answer on it
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (screen_writes_q.size() == 0) begin
               report_mismatch("unexpected result address", 16'(rsp_mon.cell_address), '0);
            end else begin
               want = screen_writes_q.pop_front();
               if (rsp_mon.kind !== want.kind)
                  report_mismatch("kind", 16'(rsp_mon.kind), 16'(want.kind));
               if (rsp_mon.cell_address !== want.cell_address)
                  report_mismatch("cell_address", 16'(rsp_mon.cell_address),
                                  16'(want.cell_address));
               if (rsp_mon.cell_data !== want.cell_data)
                  report_mismatch("cell_data", 16'(rsp_mon.cell_data), 16'(want.cell_data));
               if (rsp_mon.last !== want.last)
                  report_mismatch("last", 16'(rsp_mon.last), 16'(want.last));
            end
         end
         if (csr_mon.valid && csr_mon.ready)
            fg_color = csr_mon.text_color;
         if (req_mon.valid && req_mon.ready)
            predict_screen(req_mon.func, req_mon.char_code, req_mon.show_cursor);
      end
      queued <= screen_writes_q.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives typed text, control codes and boundary marks into the cursor engine
// with random gaps and result stalls; the screen checker judges every result
// ----------------------------------------------------------------------------
module tb_top;
   import tcce_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // generous ceiling: worst case is far below this
   localparam int CYCLE_LIMIT   = 500000;
   // items that give no result may still sit in the two-entry queue
   localparam int SETTLE_CYCLES = 20;

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   results_due;
   int   cycle_count = 0;
   bit   quiet_sender = 1'b0;

   tcce_req_if req ();
   tcce_rsp_if rsp ();
   tcce_csr_if csr ();

   text_console_cursor_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   tcce_screen_check screen_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req),
      .rsp_mon     (rsp),
      .csr_mon     (csr),
      .fail_count  (failures),
      .results_due (results_due)
   );

   always #1 clock = ~clock;

   // hard stop if the engine hangs or results go missing
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side back-pressure: short stalls, a few long ones, and long free runs
   initial begin
      int pick;
      int span;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            rsp.ready <= 1'b1;
            span = $urandom_range(1, 4);
         end else if (pick < 60) begin
            rsp.ready <= 1'b1;
            span = $urandom_range(20, 80);
         end else if (pick < 90) begin
            rsp.ready <= 1'b0;
            span = $urandom_range(1, 3);
         end else begin
            rsp.ready <= 1'b0;
            span = $urandom_range(10, 30);
         end
         repeat (span) @(posedge clock);
      end
   end

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [CHAR_W-1:0] any_byte();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // random byte with the control codes well represented
   function automatic logic [CHAR_W-1:0] rand_code();
      case ($urandom_range(0, 9))
         0:       return CODE_NEWLINE;
         1:       return CODE_BACKSPACE;
         2:       return CODE_TAB;
         default: return any_byte();
      endcase
   endfunction

   // one command item; returns on the edge that accepts it, valid left high so
   // a following item with no gap goes straight out
   task automatic send_item(input logic func, input logic [CHAR_W-1:0] ch, input logic upd);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (quiet_sender || pick < 55)
         gap = 0;
      else if (pick < 87)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.func        <= func;
      req.char_code   <= ch;
      req.show_cursor <= upd;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // sender holds off until every predicted result is back, then lets the
   // queue empty out items that give no result
   task automatic settle_engine();
      req.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // color register, only written with the engine idle
   task automatic write_color(input logic [COLOR_W-1:0] color);
      csr.valid      <= 1'b1;
      csr.text_color <= color;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
   endtask

   // random traffic built from typing-like segments plus some noise
   task automatic random_session(input int budget);
      int sent;
      int segment;
      int pick;
      int n;
      sent = 0;
      while (sent < budget) begin
         segment      = $urandom_range(0, 99);
         quiet_sender = ($urandom_range(0, 3) == 0);
         if (segment < 35) begin
            // edit session: mark, then typing, tabs and erasing mixed, often past the mark
            send_item(1'b1, any_byte(), rand_bit());
            n = $urandom_range(3, 10);
            repeat (n) begin
               pick = $urandom_range(0, 9);
               if (pick < 5)
                  send_item(1'b0, any_byte(), rand_bit());
               else if (pick < 7)
                  send_item(1'b0, CODE_TAB, rand_bit());
               else
                  send_item(1'b0, CODE_BACKSPACE, rand_bit());
            end
            sent += n + 1;
         end else if (segment < 55) begin
            // long line of text, runs the column over the right edge
            n = $urandom_range(10, 85);
            if (n > budget - sent)
               n = budget - sent;
            repeat (n) begin
               if ($urandom_range(0, 9) == 0)
                  send_item(1'b0, CODE_TAB, rand_bit());
               else
                  send_item(1'b0, any_byte(), rand_bit());
            end
            sent += n;
         end else if (segment < 70) begin
            // newline burst, walks the row down to the bottom and around
            n = $urandom_range(2, 8);
            repeat (n) send_item(1'b0, CODE_NEWLINE, rand_bit());
            sent += n;
         end else if (segment < 85) begin
            // backspace run, reaches column zero and the boundary
            n = $urandom_range(2, 10);
            repeat (n) send_item(1'b0, CODE_BACKSPACE, rand_bit());
            sent += n;
         end else begin
            // noise: anything in any field
            n = $urandom_range(3, 10);
            repeat (n) send_item(($urandom_range(0, 4) == 0), rand_code(), rand_bit());
            sent += n;
         end
      end
      quiet_sender = 1'b0;
   endtask

   initial begin
      logic [COLOR_W-1:0] phase_color;
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.func        <= 1'b0;
      req.char_code   <= '0;
      req.show_cursor <= 1'b0;
      csr.valid       <= 1'b0;
      csr.text_color  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part, color at its reset value
      send_item(1'b0, "A", 1'b1);
      send_item(1'b0, 8'h00, 1'b0);
      send_item(1'b0, 8'hFF, 1'b1);
      // no boundary yet: backspace allowed
      send_item(1'b0, CODE_BACKSPACE, 1'b1);
      send_item(1'b0, CODE_NEWLINE, 1'b1);
      send_item(1'b0, CODE_NEWLINE, 1'b0);
      // column zero: ignored, cursor update dropped as well
      send_item(1'b0, CODE_BACKSPACE, 1'b1);
      send_item(1'b0, CODE_TAB, 1'b1);
      send_item(1'b0, CODE_TAB, 1'b0);
      // mark at column six, its char and update flag are don't-care
      send_item(1'b1, 8'hFF, 1'b1);
      // previous cell lies before the boundary: ignored
      send_item(1'b0, CODE_BACKSPACE, 1'b1);
      send_item(1'b0, "x", 1'b0);
      // previous cell is the boundary itself: allowed
      send_item(1'b0, CODE_BACKSPACE, 1'b1);
      send_item(1'b0, CODE_BACKSPACE, 1'b0);
      send_item(1'b0, 8'h7F, 1'b1);
      send_item(1'b0, 8'h80, 1'b0);
      send_item(1'b1, 8'h00, 1'b0);
      send_item(1'b0, CODE_NEWLINE, 1'b1);
      settle_engine();

      // color extremes
      write_color(4'h0);
      send_item(1'b0, 8'h55, 1'b1);
      send_item(1'b0, CODE_TAB, 1'b1);
      settle_engine();
      write_color(4'hF);
      send_item(1'b0, 8'hAA, 1'b1);
      settle_engine();

      // random phases, each under its own color setting
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       phase_color = 4'h0;
            1:       phase_color = 4'hF;
            2:       phase_color = 4'h5;
            3:       phase_color = 4'hA;
            default: phase_color = COLOR_W'($urandom_range(0, 15));
         endcase
         write_color(phase_color);
         random_session(40);
         settle_engine();
      end

      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/tcce_pkg.sv
src/tcce_if.sv
src/tcce_front.sv
src/tcce_queue.sv
src/tcce_back.sv
src/text_console_cursor_engine.sv
tb/sv/tcce_screen_check.sv
tb/sv/tb_top.sv
